/* hdl/assert_macros.svh */
// Assertion helpers for the RTL; the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define TLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TLS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* hdl/tls_pkg.sv */
package tls_pkg;

    // Log geometry
    localparam int DEPTH   = 256;
    localparam int PAYLOAD = 96;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int TW      = 64;
    localparam int LW      = 7;

    localparam logic [CW-1:0] DEPTH_C    = CW'(DEPTH);
    localparam logic [15:0]   LEN_MAX_16 = 16'(PAYLOAD - 1);
    localparam logic [LW-1:0] LEN_MAX    = LW'(PAYLOAD - 1);

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_CAPTURE = 2'd1,
        MODE_STOP    = 2'd2,
        MODE_SEEK    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK
    } t_top_state;

    typedef enum logic {
        SK_IDLE,
        SK_PROBE
    } t_seek_state;

    typedef struct packed {
        t_mode           mode;
        logic [TW-1:0]   now_ms;
        logic [15:0]     length;
        logic [TW-1:0]   seek_time_ms;
    } t_in_word;

    typedef struct packed {
        logic            status;
        logic [7:0]      frame_index;
        logic [LW-1:0]   stored_length;
        logic [8:0]      frame_count;
        logic [TW-1:0]   duration_ms;
    } t_out_word;

    // Search launch from the top level
    typedef struct packed {
        logic            go;
        logic [CW-1:0]   count;
        logic [TW-1:0]   query;
    } t_seek_req;

    // Search completion
    typedef struct packed {
        logic            done;
        logic [AW-1:0]   index;
    } t_seek_rsp;

    // Log memory write port
    typedef struct packed {
        logic            we;
        logic [AW-1:0]   addr;
        logic [TW-1:0]   data;
    } t_wr_req;

endpackage

/* hdl/tls_log_mem.sv */
module tls_log_mem
    import tls_pkg::*;
(
    input  logic          i_clk,
    input  t_wr_req       i_wr,
    input  logic [AW-1:0] i_rd_addr,
    output logic [TW-1:0] o_rd_data
);

    logic [TW-1:0] r_mem [DEPTH];
    logic [TW-1:0] r_rd_data;

    // One write port for capture
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read for the search probes
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/tls_search.sv */
module tls_search
    import tls_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_seek_req     i_req,
    input  logic [TW-1:0] i_rd_data,
    output logic [AW-1:0] o_rd_addr,
    output t_seek_rsp     o_rsp
);

    t_seek_state   r_state, n_state;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hp, n_hp;      // hi + 1, so the range is [lo, hp)
    logic [AW-1:0] r_mid, n_mid;
    logic [AW-1:0] r_found, n_found;
    logic [TW-1:0] r_query, n_query;

    logic          le;
    logic [CW-1:0] lo_nx, hp_nx;
    logic [AW-1:0] found_nx;
    logic [CW:0]   mid_sum;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Search registers
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hp    <= n_hp;
        r_mid   <= n_mid;
        r_found <= n_found;
        r_query <= n_query;
    end

    // One probe per cycle: compare the word read at mid, narrow, issue next read
    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hp        = r_hp;
        n_mid       = r_mid;
        n_found     = r_found;
        n_query     = r_query;
        o_rd_addr   = r_mid;
        o_rsp.done  = 1'b0;
        o_rsp.index = r_found;

        le       = (i_rd_data <= r_query);
        lo_nx    = le ? (CW'(r_mid) + CW'(1)) : r_lo;
        hp_nx    = le ? r_hp : CW'(r_mid);
        found_nx = le ? r_mid : r_found;
        mid_sum  = (CW+1)'(lo_nx) + (CW+1)'(hp_nx) - (CW+1)'(1);

        unique case (r_state)
            SK_IDLE: begin
                if (i_req.go) begin
                    // count is at least one here
                    n_lo      = '0;
                    n_hp      = i_req.count;
                    n_query   = i_req.query;
                    n_found   = '0;
                    n_mid     = AW'((i_req.count - CW'(1)) >> 1);
                    o_rd_addr = n_mid;
                    n_state   = SK_PROBE;
                end
            end
            SK_PROBE: begin
                n_lo    = lo_nx;
                n_hp    = hp_nx;
                n_found = found_nx;
                if (lo_nx < hp_nx) begin
                    n_mid     = AW'(mid_sum >> 1);
                    o_rd_addr = n_mid;
                end else begin
                    o_rsp.done  = 1'b1;
                    o_rsp.index = found_nx;
                    n_state     = SK_IDLE;
                end
            end
            default: n_state = SK_IDLE;
        endcase
    end

endmodule

/* hdl/timestamp_log_seek.sv */
// timestamp_log_seek: a log of up to DEPTH frame timestamps with a search.
// Input channel (i_in_valid / o_in_ready, i_in_word) takes one command word:
// start, capture, stop or seek. Output channel (o_out_valid / i_out_ready,
// o_out_word) returns exactly one result word per command.
// Start, capture and stop finish in the accept cycle: the result is valid
// in the cycle after acceptance, so they sustain one word per cycle while
// the receiver keeps up. Seek runs a binary search that probes the timestamp
// memory once per cycle through its single registered read port; the result
// is registered when the search completes.
// One command is in flight at a time. A new command is taken once the block
// is idle and the output register is empty or being drained in that cycle.
// When the receiver stalls, the result word holds and o_in_ready stays low.
// Reset clears the frame count, start time and recording flag, empties the
// output register and returns the search to idle; the timestamp memory is
// not cleared, only entries below the count are ever read.
`include "assert_macros.svh"

module timestamp_log_seek
    import tls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_top_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [TW-1:0] r_start, n_start;
    logic          r_recording, n_recording;
    logic [TW-1:0] r_last, n_last;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    logic          in_fire;
    logic          out_free;
    logic [TW-1:0] rel_time;
    logic [LW-1:0] clip_len;
    logic          cap_ok;
    t_seek_req     seek_req;
    t_seek_rsp     seek_rsp;
    t_wr_req       wr_req;
    logic [AW-1:0] rd_addr;
    logic [TW-1:0] rd_data;

    tls_log_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tls_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (seek_req),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_rsp     (seek_rsp)
    );

    // Handshake
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Capture datapath
    assign rel_time = i_in_word.now_ms - r_start;
    assign clip_len = (i_in_word.length < LEN_MAX_16) ? LW'(i_in_word.length) : LEN_MAX;
    assign cap_ok   = r_recording && (r_count < DEPTH_C);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_start     <= '0;
            r_recording <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_start     <= n_start;
            r_recording <= n_recording;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_out  <= n_out;
    end

    // Command decode and result assembly
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_start     = r_start;
        n_recording = r_recording;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        wr_req.we      = 1'b0;
        wr_req.addr    = AW'(r_count);
        wr_req.data    = rel_time;
        seek_req.go    = 1'b0;
        seek_req.count = r_count;
        seek_req.query = i_in_word.seek_time_ms;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_out.status        = 1'b0;
                    n_out.frame_index   = '0;
                    n_out.stored_length = '0;
                    unique case (i_in_word.mode)
                        MODE_START: begin
                            n_count     = '0;
                            n_start     = i_in_word.now_ms;
                            n_recording = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        MODE_CAPTURE: begin
                            if (cap_ok) begin
                                wr_req.we           = 1'b1;
                                n_last              = rel_time;
                                n_count             = r_count + CW'(1);
                                n_out.frame_index   = 8'(r_count);
                                n_out.stored_length = clip_len;
                            end else begin
                                n_out.status = 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        MODE_STOP: begin
                            n_recording = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        MODE_SEEK: begin
                            if (r_count == '0) begin
                                n_out.status = 1'b1;
                                n_out_valid  = 1'b1;
                            end else begin
                                seek_req.go = 1'b1;
                                n_state     = ST_SEEK;
                            end
                        end
                        default: n_out_valid = 1'b1;
                    endcase
                    n_out.frame_count = 9'(n_count);
                    n_out.duration_ms = (n_count == '0) ? '0 : n_last;
                end
            end
            ST_SEEK: begin
                if (seek_rsp.done) begin
                    n_out.status        = 1'b0;
                    n_out.frame_index   = 8'(seek_rsp.index);
                    n_out.stored_length = '0;
                    n_out.frame_count   = 9'(r_count);
                    n_out.duration_ms   = r_last;
                    n_out_valid         = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Checks
    `TLS_ASSERT(a_count_bound, r_count <= DEPTH_C, "frame count above log depth")
    `TLS_ASSERT(a_done_in_seek, seek_rsp.done |-> (r_state == ST_SEEK), "search done while not seeking")
    `TLS_ASSERT(a_empty_duration, (o_out_valid && o_out_word.frame_count == '0) |-> (o_out_word.duration_ms == '0), "empty log reports nonzero duration")
    `TLS_ASSERT(a_capture_count, (in_fire && i_in_word.mode == MODE_CAPTURE && cap_ok) |=> (r_count == $past(r_count) + CW'(1)), "capture did not advance count")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tls_pkg::*;

    localparam int            ITEMS_TOTAL   = 650;
    localparam int            PLAN_ROWS     = 22;
    localparam int            IDLE_LIMIT    = 2000;
    localparam int            HOLD_CYCLES   = 120;
    localparam int            SETTLE_CYCLES = 16;
    localparam logic [TW-1:0] ALL_ONES      = {TW{1'b1}};

    // one directed row: command word plus an optional hand-written result
    typedef struct packed {
        t_in_word  cmd;
        logic      pinned;
        t_out_word want;
    } t_plan_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    t_in_word  cmd_word  = '0;
    logic      cmd_ready;
    logic      res_valid;
    logic      res_ready = 1'b0;
    t_out_word res_word;

    // shadow copy of the frame log
    logic [TW-1:0] log_time [DEPTH];
    logic [CW-1:0] log_count     = '0;
    logic [TW-1:0] log_origin    = '0;
    logic          log_recording = 1'b0;

    t_out_word result_q[$];
    t_out_word result_due;
    int        errors       = 0;
    int        words_sent   = 0;
    int        burst_left   = 0;
    int        results_seen = 0;
    int        hold_left    = 0;
    bit        hold_done    = 1'b0;
    int        seg_left     = 0;
    int        seg_mode     = 0;
    int        seg_phase    = 0;
    int        idle_cycles  = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    timestamp_log_seek i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_ready  (cmd_ready),
        .i_in_word   (cmd_word),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_word  (res_word)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_word cmd(t_mode mode, logic [TW-1:0] now, logic [15:0] len,
                                     logic [TW-1:0] query);
        t_in_word w;
        w.mode         = mode;
        w.now_ms       = now;
        w.length       = len;
        w.seek_time_ms = query;
        return w;
    endfunction

    function automatic t_out_word res(logic status, logic [7:0] index, logic [LW-1:0] stored,
                                      logic [8:0] frames, logic [TW-1:0] duration);
        t_out_word r;
        r.status        = status;
        r.frame_index   = index;
        r.stored_length = stored;
        r.frame_count   = frames;
        r.duration_ms   = duration;
        return r;
    endfunction

    function automatic t_plan_row pinned_row(t_in_word c, t_out_word r);
        t_plan_row p;
        p.cmd    = c;
        p.pinned = 1'b1;
        p.want   = r;
        return p;
    endfunction

    function automatic t_plan_row derived_row(t_in_word c);
        t_plan_row p;
        p.cmd    = c;
        p.pinned = 1'b0;
        p.want   = '0;
        return p;
    endfunction

    // Applies one command to the shadow log and returns the result word
    function automatic t_out_word log_step(t_in_word w);
        t_out_word     r;
        logic [LW-1:0] clip;
        int            lo;
        int            hi;
        int            mid;
        int            found;
        r = '0;
        case (w.mode)
            MODE_START: begin
                log_count     = '0;
                log_origin    = w.now_ms;
                log_recording = 1'b1;
            end
            MODE_CAPTURE: begin
                if (!log_recording || log_count >= DEPTH_C) begin
                    r.status = 1'b1;
                end else begin
                    clip = (w.length < LEN_MAX_16) ? w.length[LW-1:0] : LEN_MAX;
                    r.frame_index   = log_count[7:0];
                    r.stored_length = clip;
                    log_time[log_count[AW-1:0]] = w.now_ms - log_origin;
                    log_count = log_count + 1'b1;
                end
            end
            MODE_STOP: begin
                log_recording = 1'b0;
            end
            default: begin
                // last entry at or below the query, probed lo/hi/mid
                if (log_count == 0) begin
                    r.status = 1'b1;
                end else begin
                    lo    = 0;
                    hi    = int'(log_count) - 1;
                    found = 0;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        if (log_time[mid] <= w.seek_time_ms) begin
                            found = mid;
                            lo    = mid + 1;
                        end else begin
                            hi = mid - 1;
                        end
                    end
                    r.frame_index = 8'(found);
                end
            end
        endcase
        r.frame_count = log_count;
        if (log_count != 0)
            r.duration_ms = log_time[AW'(log_count - 1'b1)];
        return r;
    endfunction

    function automatic logic [15:0] pick_length();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 94));
            1:       return 16'($urandom_range(94, 97));
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly hits stored times or their neighbors so the search goes deep
    function automatic logic [TW-1:0] pick_query();
        int k;
        if (log_count == 0 || $urandom_range(0, 4) == 0)
            return rand64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            default: begin
                k = $urandom_range(0, int'(log_count) - 1);
                return log_time[k] + TW'($urandom_range(0, 2)) - 1'b1;
            end
        endcase
    endfunction

    // Offers one command word in bursts with random gaps in between
    task automatic send_word(input t_in_word w, input logic pinned, input t_out_word want);
        int        gap;
        t_out_word predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        do @(posedge clk); while (!cmd_ready);
        predicted = log_step(w);
        result_q.push_back(pinned ? want : predicted);
        burst_left--;
        words_sent++;
    endtask

    // A recording session: start, then captures, seeks, stops and noise
    task automatic run_session(input int n);
        logic [TW-1:0] clock_ms;
        int            pick;
        clock_ms = ($urandom_range(0, 3) == 0) ? ~TW'($urandom_range(0, 5000)) : rand64();
        send_word(cmd(MODE_START, clock_ms, 16'($urandom), rand64()), 1'b0, '0);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                case ($urandom_range(0, 9))
                    0:       clock_ms = rand64();   // out of order
                    1:       ;                      // repeated time
                    default: clock_ms = clock_ms + TW'($urandom_range(1, 2000));
                endcase
                send_word(cmd(MODE_CAPTURE, clock_ms, pick_length(), rand64()), 1'b0, '0);
            end else if (pick < 85) begin
                send_word(cmd(MODE_SEEK, rand64(), 16'($urandom), pick_query()), 1'b0, '0);
            end else if (pick < 90) begin
                send_word(cmd(MODE_STOP, rand64(), 16'($urandom), rand64()), 1'b0, '0);
            end else begin
                send_word(cmd(t_mode'($urandom_range(0, 3)), rand64(), 16'($urandom), rand64()),
                          1'b0, '0);
            end
        end
    endtask

    // Fill the log to the brim, overflow it, then search the full log
    task automatic fill_log();
        logic [TW-1:0] clock_ms;
        clock_ms = rand64();
        send_word(cmd(MODE_START, clock_ms, 16'($urandom), rand64()), 1'b0, '0);
        repeat (DEPTH + 3) begin
            clock_ms = clock_ms + TW'($urandom_range(0, 50));
            send_word(cmd(MODE_CAPTURE, clock_ms, pick_length(), rand64()), 1'b0, '0);
        end
        repeat (12)
            send_word(cmd(MODE_SEEK, rand64(), 16'($urandom), pick_query()), 1'b0, '0);
        send_word(cmd(MODE_STOP, rand64(), 16'($urandom), rand64()), 1'b0, '0);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Stimulus
    initial begin
        t_plan_row plan [PLAN_ROWS];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        plan = '{
            pinned_row(cmd(MODE_CAPTURE, 64'h0123_4567_89AB_CDEF, 16'hFFFF, '0),
                       res(1'b1, 8'd0, 7'd0, 9'd0, '0)),
            pinned_row(cmd(MODE_SEEK, '0, 16'h0000, ALL_ONES),
                       res(1'b1, 8'd0, 7'd0, 9'd0, '0)),
            pinned_row(cmd(MODE_STOP, ALL_ONES, 16'hFFFF, ALL_ONES),
                       res(1'b0, 8'd0, 7'd0, 9'd0, '0)),
            pinned_row(cmd(MODE_START, 64'hFFFF_FFFF_FFFF_FFF0, 16'h0000, '0),
                       res(1'b0, 8'd0, 7'd0, 9'd0, '0)),
            // time wraps: 5 - (2^64 - 16) = 21
            pinned_row(cmd(MODE_CAPTURE, 64'h5, 16'hFFFF, '0),
                       res(1'b0, 8'd0, LEN_MAX, 9'd1, 64'h15)),
            pinned_row(cmd(MODE_CAPTURE, 64'hFFFF_FFFF_FFFF_FFF0, 16'h0000, ALL_ONES),
                       res(1'b0, 8'd1, 7'd0, 9'd2, '0)),
            derived_row(cmd(MODE_CAPTURE, 64'h64, 16'd95, '0)),
            derived_row(cmd(MODE_CAPTURE, 64'h64, 16'd94, '0)),
            derived_row(cmd(MODE_CAPTURE, 64'h7FFF_FFFF_FFFF_FFFF, 16'd96, '0)),
            derived_row(cmd(MODE_SEEK, '0, 16'h0000, '0)),
            derived_row(cmd(MODE_SEEK, '0, 16'h0000, 64'h15)),
            derived_row(cmd(MODE_SEEK, '0, 16'h0000, ALL_ONES)),
            derived_row(cmd(MODE_STOP, '0, 16'h0000, '0)),
            derived_row(cmd(MODE_CAPTURE, 64'h1000, 16'd5, '0)),
            pinned_row(cmd(MODE_START, '0, 16'h0000, '0),
                       res(1'b0, 8'd0, 7'd0, 9'd0, '0)),
            // restart while recording
            pinned_row(cmd(MODE_START, 64'd1000, 16'h0000, '0),
                       res(1'b0, 8'd0, 7'd0, 9'd0, '0)),
            derived_row(cmd(MODE_CAPTURE, 64'd1200, 16'h8000, '0)),
            derived_row(cmd(MODE_CAPTURE, 64'd1300, 16'd1, '0)),
            derived_row(cmd(MODE_CAPTURE, 64'd1400, 16'h7FFF, '0)),
            // query below the first entry
            derived_row(cmd(MODE_SEEK, '0, 16'h0000, 64'd50)),
            derived_row(cmd(MODE_SEEK, '0, 16'h0000, 64'd250)),
            derived_row(cmd(MODE_SEEK, '0, 16'h0000, 64'd300))
        };
        for (int k = 0; k < PLAN_ROWS; k++)
            send_word(plan[k].cmd, plan[k].pinned, plan[k].want);

        while (words_sent < ITEMS_TOTAL / 3)
            run_session($urandom_range(4, 60));
        fill_log();
        while (words_sent < ITEMS_TOTAL)
            run_session($urandom_range(4, 60));
        cmd_valid <= 1'b0;

        while (result_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("timestamp_log_seek verification clean");
        else
            $display("timestamp_log_seek verification failed");
        $finish;
    end

    // Result checker and receiver stall pattern
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            results_seen++;
            if (result_q.size() == 0) begin
                $error("result word 0x%0h with nothing expected", res_word);
                errors++;
            end else begin
                result_due = result_q.pop_front();
                check_field("status", result_due.status, res_word.status);
                check_field("frame_index", result_due.frame_index, res_word.frame_index);
                check_field("stored_length", result_due.stored_length, res_word.stored_length);
                check_field("frame_count", result_due.frame_count, res_word.frame_count);
                check_field("duration_ms", result_due.duration_ms, res_word.duration_ms);
            end
        end

        // one long hold-off early on so the block backs up into its input
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            res_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 2);
                seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            seg_phase++;
            case (seg_mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= ($urandom_range(0, 2) != 0);
                default: res_ready <= (seg_phase % 7) >= 3;
            endcase
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timestamp_log_seek verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* files.f */
+incdir+hdl
hdl/tls_pkg.sv
hdl/tls_log_mem.sv
hdl/tls_search.sv
hdl/timestamp_log_seek.sv
tb/sv/tb.sv
